// File: rtl/cmhb_pkg.sv
// Shared types, constants and helpers for the coupled hash bucket index unit.
// No dependencies; every other file imports this package.
`default_nettype none
package cmhb_pkg;

  localparam int HN_W     = 8;
  localparam int KEY_W    = 32;
  localparam int BUCKET_W = 24;
  localparam int TS_W     = 25;
  localparam int Z_W      = 24;
  localparam int MODE_W   = 2;
  localparam int HC_W     = 7;
  localparam int CA_W     = 17;
  localparam int MW       = TS_W;
  localparam int DEF_INDEX_WIDTH = 24;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam int HASH_STAGES = 5;
  localparam int MOD_BPS     = 2;
  localparam int MOD_STAGES  = KEY_W / MOD_BPS;
  localparam int PIPE_STAGES = HASH_STAGES + MOD_STAGES;

  localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2     = 32'h1b873593;
  localparam logic [31:0] MM_N      = 32'he6546b64;
  localparam logic [31:0] MM_F1     = 32'h85ebca6b;
  localparam logic [31:0] MM_F2     = 32'hc2b2ae35;
  localparam logic [31:0] MM_LEN    = 32'd4;
  localparam logic [31:0] SEED_BASE = 32'd114514;

  localparam logic [TS_W-1:0] RST_TABLE_SIZE = TS_W'(1024);
  localparam logic [Z_W-1:0]  RST_COUPLING_Z = '0;
  localparam logic [HC_W-1:0] RST_HASH_COUNT = HC_W'(3);
  localparam logic [CA_W-1:0] RST_CIRCULAR_A = CA_W'(21845);
  localparam logic [HC_W-1:0] AUTO_CIRC_MAX  = HC_W'(2);

  typedef enum logic [MODE_W-1:0] {
    MODE_AUTO     = 2'd0,
    MODE_RANDOM   = 2'd1,
    MODE_CIRCULAR = 2'd2,
    MODE_NAIVE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_TABLE_SIZE = 3'd0,
    REG_COUPLING_Z = 3'd1,
    REG_HASH_MODE  = 3'd2,
    REG_HASH_COUNT = 3'd3,
    REG_CIRCULAR_A = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MW-1:0] m;
    logic [MW-1:0] off_div;
    logic [MW-1:0] base_div;
    logic          wrap;
    logic          random;
  } derived_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
    rotl32 = (v << r) | (v >> (32 - r));
  endfunction

endpackage
`default_nettype wire

// File: rtl/cmhb_ifs.sv
// Valid/ready stream interfaces for the key input and the bucket result.
// Depends on cmhb_pkg.
`default_nettype none
interface cmhb_in_if
  import cmhb_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [HN_W-1:0]         hash_number;
  logic signed [KEY_W-1:0] key;
  modport source (output valid, hash_number, key, input ready);
  modport sink   (input valid, hash_number, key, output ready);
endinterface

interface cmhb_out_if
  import cmhb_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket;
  modport source (output valid, bucket, input ready);
  modport sink   (input valid, bucket, output ready);
endinterface
`default_nettype wire

// File: rtl/coupled_hash_bucket_index_unit.sv
// Top level: murmur hash pipeline, two remainder pipelines, combine stage.
// Depends on cmhb_pkg, cmhb_ifs, cmhb_cfg, cmhb_murmur, cmhb_mod.
//
//  channel  | dir | handshake          | beat
//  in_bus   | in  | valid/ready        | hash_number, key
//  out_bus  | out | valid/ready        | bucket
//  cfg_*    | in  | APB, pready high   | 5 registers at 4*i
//
// One beat per cycle sustained while out_bus is ready and the sequencer is idle.
// After reset and after each register write the divisor sequencer runs its load,
// 25-step range-length divide, shrink multiply and clamp; in_bus.ready is low while it runs.
// A stall on out_bus freezes the whole pipeline; no beat is lost or repeated.
`default_nettype none
module coupled_hash_bucket_index_unit
  import cmhb_pkg::*;
#(
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  cmhb_in_if.sink                in_bus,
  cmhb_out_if.source             out_bus,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  derived_t             dcfg;
  logic                 busy, pipe_en;
  logic [PIPE_STAGES-1:0] vld_r;
  logic                 out_valid_r;
  logic [BUCKET_W-1:0]  bucket_r;
  logic [31:0]          hash_off, hash_base;
  logic [MW-1:0]        cur, base, sel;
  logic [MW:0]          sum;

  cmhb_cfg #(.INDEX_WIDTH(INDEX_WIDTH)) u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .dcfg, .busy
  );

  assign pipe_en      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = pipe_en && !busy;

  cmhb_murmur u_hash (
    .clk, .en(pipe_en), .random(dcfg.random),
    .hash_number(in_bus.hash_number), .key($unsigned(in_bus.key)),
    .hash_off, .hash_base
  );

  cmhb_mod u_mod_off (
    .clk, .en(pipe_en), .dividend(hash_off), .divisor(dcfg.off_div), .remainder(cur)
  );

  cmhb_mod u_mod_base (
    .clk, .en(pipe_en), .dividend(hash_base), .divisor(dcfg.base_div), .remainder(base)
  );

  always_comb begin
    sum = {1'b0, base} + {1'b0, cur};
    if (dcfg.wrap && (sum >= {1'b0, dcfg.m})) begin
      sum = sum - {1'b0, dcfg.m};
    end
    sel = dcfg.random ? cur : sum[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      vld_r       <= {vld_r[PIPE_STAGES-2:0], in_bus.valid && in_bus.ready};
      out_valid_r <= vld_r[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      bucket_r <= sel[BUCKET_W-1:0];
    end
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.bucket = bucket_r;

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_bus.ready)
    else $error("input taken while divisors are recomputed");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> vld_r == $past(vld_r))
    else $error("pipeline moved during a stall");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[PIPE_STAGES-1]))
    else $error("result without a beat in the last stage");

endmodule
`default_nettype wire

// File: rtl/cmhb_cfg.sv
// Configuration registers, APB write/read, and a sequencer that derives the
// range length and modulo divisors after reset and after every write. Uses cmhb_pkg.
`default_nettype none
module cmhb_cfg
  import cmhb_pkg::*;
#(
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output derived_t               dcfg,
  output logic                   busy
);

  localparam logic [32:0] MAXM = 33'd1 << INDEX_WIDTH;
  localparam int CNT_W = $clog2(MW);
  localparam int PW    = CA_W + MW;

  typedef enum logic [2:0] {ST_LOAD, ST_DIV, ST_MUL, ST_FIN, ST_IDLE} seq_t;

  seq_t             state_r;
  logic [TS_W-1:0]  table_size_r;
  logic [Z_W-1:0]   coupling_z_r;
  logic [MODE_W-1:0] hash_mode_r;
  logic [HC_W-1:0]  hash_count_r;
  logic [CA_W-1:0]  circular_a_r;
  logic [MW-1:0]    rem_r, quo_r, dsr_r, m_r, r_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PW-1:0]    prod_r;
  derived_t         dcfg_r;

  logic             wr_en;
  reg_idx_t         widx;
  logic [MW-1:0]    m_eff, r_c;
  logic [MW:0]      trial;
  logic             take;
  logic [MW:0]      shrink;
  logic signed [MW+2:0] br;
  logic [MW-1:0]    br_cl;
  mode_t            emode;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign widx  = reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    if (table_size_r == '0) begin
      m_eff = MW'(1);
    end else if ({8'd0, table_size_r} > MAXM) begin
      m_eff = MW'(MAXM);
    end else begin
      m_eff = table_size_r;
    end
    trial  = {rem_r, quo_r[MW-1]};
    take   = trial >= {1'b0, dsr_r};
    r_c    = (quo_r == '0) ? MW'(1) : quo_r;
    shrink = prod_r[PW-1:16];
    br     = $signed({3'd0, m_r}) - $signed({2'd0, shrink}) + 28'sd1;
    if (br > $signed({3'd0, m_r})) begin
      br_cl = m_r;
    end else if (br < 28'sd1) begin
      br_cl = MW'(1);
    end else begin
      br_cl = br[MW-1:0];
    end
    if (mode_t'(hash_mode_r) == MODE_AUTO) begin
      emode = (hash_count_r <= AUTO_CIRC_MAX) ? MODE_CIRCULAR : MODE_NAIVE;
    end else begin
      emode = mode_t'(hash_mode_r);
    end
  end

  always_comb begin
    case (widx)
      REG_TABLE_SIZE: cfg_prdata = CFG_DW'(table_size_r);
      REG_COUPLING_Z: cfg_prdata = CFG_DW'(coupling_z_r);
      REG_HASH_MODE:  cfg_prdata = CFG_DW'(hash_mode_r);
      REG_HASH_COUNT: cfg_prdata = CFG_DW'(hash_count_r);
      REG_CIRCULAR_A: cfg_prdata = CFG_DW'(circular_a_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      table_size_r <= RST_TABLE_SIZE;
      coupling_z_r <= RST_COUPLING_Z;
      hash_mode_r  <= MODE_AUTO;
      hash_count_r <= RST_HASH_COUNT;
      circular_a_r <= RST_CIRCULAR_A;
    end else if (wr_en) begin
      state_r <= ST_LOAD;
      case (widx)
        REG_TABLE_SIZE: table_size_r <= cfg_pwdata[TS_W-1:0];
        REG_COUPLING_Z: coupling_z_r <= cfg_pwdata[Z_W-1:0];
        REG_HASH_MODE:  hash_mode_r  <= cfg_pwdata[MODE_W-1:0];
        REG_HASH_COUNT: hash_count_r <= cfg_pwdata[HC_W-1:0];
        REG_CIRCULAR_A: circular_a_r <= cfg_pwdata[CA_W-1:0];
        default: ;
      endcase
    end else begin
      case (state_r)
        ST_LOAD: begin
          rem_r   <= '0;
          quo_r   <= m_eff;
          m_r     <= m_eff;
          dsr_r   <= MW'({1'b0, coupling_z_r}) + MW'(1);
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= take ? MW'(trial - {1'b0, dsr_r}) : trial[MW-1:0];
          quo_r <= {quo_r[MW-2:0], take};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(MW - 1)) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          r_r     <= r_c;
          prod_r  <= PW'(circular_a_r) * PW'(r_c);
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          dcfg_r.m        <= m_r;
          dcfg_r.random   <= (emode == MODE_RANDOM);
          dcfg_r.wrap     <= (emode == MODE_CIRCULAR);
          dcfg_r.off_div  <= (emode == MODE_RANDOM) ? m_r : r_r;
          dcfg_r.base_div <= (emode == MODE_CIRCULAR) ? br_cl : (m_r - r_r + MW'(1));
          state_r         <= ST_IDLE;
        end
        ST_IDLE: state_r <= ST_IDLE;
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign dcfg = dcfg_r;
  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// File: rtl/cmhb_murmur.sv
// Five-stage pipelined 4-byte murmur3 x86_32 for two seeds over one key.
// Uses cmhb_pkg.
`default_nettype none
module cmhb_murmur
  import cmhb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              random,
  input  wire logic [HN_W-1:0]   hash_number,
  input  wire logic [KEY_W-1:0]  key,
  output logic      [31:0]       hash_off,
  output logic      [31:0]       hash_base
);

  logic [31:0] k1_r, k2_r, sa1_r, sa2_r;
  logic [31:0] ha3_r, hb3_r, ha4_r, hb4_r, ha5_r, hb5_r;
  logic [15:0] sq;
  logic [31:0] seed_c, xa3, xb3, xa4, xb4;

  always_comb begin
    sq     = 16'(hash_number) * 16'(hash_number);
    seed_c = random ? (32'(sq) * 32'd3 + 32'(hash_number) + 32'd2) : 32'(hash_number);
    xa3    = ha3_r ^ MM_LEN;
    xa3    = xa3 ^ (xa3 >> 16);
    xb3    = hb3_r ^ MM_LEN;
    xb3    = xb3 ^ (xb3 >> 16);
    xa4    = ha4_r ^ (ha4_r >> 13);
    xb4    = hb4_r ^ (hb4_r >> 13);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_r  <= key * MM_C1;
      sa1_r <= seed_c;
      k2_r  <= rotl32(k1_r, 15) * MM_C2;
      sa2_r <= sa1_r;
      ha3_r <= rotl32(sa2_r ^ k2_r, 13) * 32'd5 + MM_N;
      hb3_r <= rotl32(SEED_BASE ^ k2_r, 13) * 32'd5 + MM_N;
      ha4_r <= xa3 * MM_F1;
      hb4_r <= xb3 * MM_F1;
      ha5_r <= xa4 * MM_F2;
      hb5_r <= xb4 * MM_F2;
    end
  end

  assign hash_off  = ha5_r ^ (ha5_r >> 16);
  assign hash_base = hb5_r ^ (hb5_r >> 16);

endmodule
`default_nettype wire

// File: rtl/cmhb_mod.sv
// Pipelined restoring remainder of a 32-bit word by a static divisor,
// MOD_BPS quotient bits per stage. Uses cmhb_pkg.
`default_nettype none
module cmhb_mod
  import cmhb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [KEY_W-1:0] dividend,
  input  wire logic [MW-1:0]    divisor,
  output logic      [MW-1:0]    remainder
);

  logic [MW-1:0]    rem_r [MOD_STAGES];
  logic [KEY_W-1:0] dvd_r [MOD_STAGES-1];

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_st
    logic [MW-1:0]    rin, rn;
    logic [KEY_W-1:0] din, dn;

    if (s == 0) begin : g_first
      assign rin = '0;
      assign din = dividend;
    end else begin : g_next
      assign rin = rem_r[s-1];
      assign din = dvd_r[s-1];
    end

    always_comb begin
      logic [MW:0] t;
      rn = rin;
      dn = din;
      for (int j = 0; j < MOD_BPS; j++) begin
        t  = {rn, dn[KEY_W-1]};
        dn = dn << 1;
        if (t >= {1'b0, divisor}) begin
          t = t - {1'b0, divisor};
        end
        rn = t[MW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rn;
      end
    end

    if (s < MOD_STAGES - 1) begin : g_dvd
      always_ff @(posedge clk) begin
        if (en) begin
          dvd_r[s] <= dn;
        end
      end
    end
  end

  assign remainder = rem_r[MOD_STAGES-1];

endmodule
`default_nettype wire

// File: verif/coupled_hash_bucket_index_unit_tb.sv
// Self-checking testbench for coupled_hash_bucket_index_unit: murmur-based bucket
// prediction per beat, APB register phases, random idling and back-pressure.
// Depends on cmhb_pkg, cmhb_ifs and the unit's RTL.
`timescale 1ns / 100ps

class bucket_scoreboard;
  logic [23:0] pending_buckets[$];
  int unsigned mismatches;
  bit [24:0] tbl_size;
  bit [23:0] cpl_z;
  bit [1:0] mode_sel;
  bit [6:0] hcount;
  bit [16:0] shrink_a;

  function void reset_regs();
    tbl_size = 25'd1024;
    cpl_z = '0;
    mode_sel = cmhb_pkg::MODE_AUTO;
    hcount = 7'd3;
    shrink_a = 17'd21845;
  endfunction

  function bit [31:0] rot(bit [31:0] v, int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function bit [31:0] murmur(bit [31:0] key, bit [31:0] seed);
    bit [31:0] h;
    bit [31:0] k;
    k = key * 32'hcc9e2d51;
    k = rot(k, 15);
    k = k * 32'h1b873593;
    h = seed ^ k;
    h = rot(h, 13);
    h = h * 32'd5 + 32'he6546b64;
    h ^= 32'd4;
    h ^= h >> 16;
    h = h * 32'h85ebca6b;
    h ^= h >> 13;
    h = h * 32'hc2b2ae35;
    h ^= h >> 16;
    return h;
  endfunction

  function void note_input(bit [7:0] hn, bit [31:0] key);
    longint unsigned m, r, cur, base, shr, bkt;
    longint br;
    bit [1:0] md;
    bit [31:0] seed;
    m = tbl_size;
    if (m == 0) m = 1;
    if (m > 64'd16777216) m = 64'd16777216;
    md = mode_sel;
    if (md == cmhb_pkg::MODE_AUTO)
      md = (hcount <= 2) ? cmhb_pkg::MODE_CIRCULAR : cmhb_pkg::MODE_NAIVE;
    if (md == cmhb_pkg::MODE_RANDOM) begin
      seed = 32'd3 * hn * hn + hn + 32'd2;
      bkt = murmur(key, seed) % m;
    end else begin
      r = m / (longint'(cpl_z) + 1);
      if (r == 0) r = 1;
      cur = murmur(key, {24'd0, hn}) % r;
      base = murmur(key, 32'd114514);
      if (md == cmhb_pkg::MODE_CIRCULAR) begin
        shr = (longint'(shrink_a) * r) >> 16;
        br = longint'(m) - longint'(shr) + 1;
        if (br > longint'(m)) br = m;
        if (br < 1) br = 1;
        bkt = (base % br + cur) % m;
      end else begin
        bkt = base % (m - r + 1) + cur;
      end
    end
    pending_buckets.push_back(bkt[23:0]);
  endfunction

  function void check_bucket(logic [23:0] got);
    logic [23:0] exp_b;
    if (pending_buckets.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected bucket beat %h", got);
      return;
    end
    exp_b = pending_buckets.pop_front();
    if (got !== exp_b) begin
      mismatches++;
      if (mismatches <= 10) $display("bucket mismatch: expected %h actual %h", exp_b, got);
    end
  endfunction
endclass

module coupled_hash_bucket_index_unit_tb;
  import cmhb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  cmhb_in_if in_bus ();
  cmhb_out_if out_bus ();

  coupled_hash_bucket_index_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  bucket_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.hash_number = '0;
    in_bus.key = '0;
    out_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_bucket(out_bus.bucket);
    if (rst_n && in_bus.valid && in_bus.ready) sb.note_input(in_bus.hash_number, in_bus.key);
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("coupled_hash_bucket_index_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(4 * idx);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_TABLE_SIZE: sb.tbl_size = val[24:0];
      REG_COUPLING_Z: sb.cpl_z = val[23:0];
      REG_HASH_MODE:  sb.mode_sel = val[1:0];
      REG_HASH_COUNT: sb.hcount = val[6:0];
      default:        sb.shrink_a = val[16:0];
    endcase
  endtask

  task automatic drain();
    while (sb.pending_buckets.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_key(logic [7:0] hn, logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.hash_number <= hn;
    in_bus.key <= key;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic end_burst();
    in_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] m, logic [31:0] z, mode_t md,
                            logic [31:0] k, logic [31:0] a);
    drain();
    write_reg(REG_TABLE_SIZE, m);
    write_reg(REG_COUPLING_Z, z);
    write_reg(REG_HASH_MODE, md);
    write_reg(REG_HASH_COUNT, k);
    write_reg(REG_CIRCULAR_A, a);
  endtask

  task automatic random_burst(int n);
    for (int j = 0; j < n; j++)
      send_key($urandom_range(255), $urandom());
    end_burst();
  endtask

  task automatic random_config();
    logic [31:0] m;
    logic [31:0] z;
    case ($urandom_range(3))
      0: m = $urandom_range(1, 64);
      1: m = $urandom_range(1, 32'h1FFFFFF);
      2: m = 32'd16777216;
      default: m = $urandom_range(1, 4096);
    endcase
    z = ($urandom_range(3) == 0) ? $urandom_range(0, 32'hFFFFFF) : $urandom_range(0, 15);
    set_config(m, z, mode_t'($urandom_range(3)), $urandom_range(0, 127),
               $urandom_range(0, 32'h1FFFF));
  endtask

  initial begin
    sb.reset_regs();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, field extremes, all modes and corner configs
    send_key(8'd0, 32'h0);
    send_key(8'd255, 32'hFFFFFFFF);
    send_key(8'd0, 32'h80000000);
    send_key(8'd255, 32'h7FFFFFFF);
    end_burst();
    set_config(0, 0, MODE_RANDOM, 1, 0);
    send_key(8'd7, 32'h12345678);
    end_burst();
    set_config(32'h1FFFFFF, 32'hFFFFFF, MODE_CIRCULAR, 2, 32'h1FFFF);
    send_key(8'd255, 32'hFFFFFFFF);
    send_key(8'd1, 32'h0);
    end_burst();
    set_config(16777216, 3, MODE_NAIVE, 64, 65536);
    send_key(8'd128, 32'hA5A5A5A5);
    send_key(8'd3, 32'h5A5A5A5A);
    end_burst();
    set_config(1000, 2000, MODE_NAIVE, 127, 0);
    send_key(8'd9, 32'hDEADBEEF);
    end_burst();
    set_config(100, 4, MODE_AUTO, 0, 21845);
    send_key(8'd2, 32'h1);
    send_key(8'd4, 32'hFFFFFFFE);
    end_burst();
    set_config(100, 4, MODE_AUTO, 2, 65535);
    send_key(8'd2, 32'h1);
    end_burst();
    set_config(100, 4, MODE_AUTO, 3, 1);
    send_key(8'd2, 32'h1);
    send_key(8'd200, 32'hCAFEF00D);
    end_burst();

    send_idle_pct = 12;
    recv_idle_pct = 77;
    for (int p = 0; p < 5; p++) begin
      random_config();
      random_burst(90);
    end
    hold_off_cycles = 300;
    random_burst(100);

    send_idle_pct = 77;
    recv_idle_pct = 12;
    for (int p = 0; p < 4; p++) begin
      random_config();
      random_burst(100);
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int p = 0; p < 5; p++) begin
      random_config();
      random_burst(90);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_buckets.size() == 0)
      $display("coupled_hash_bucket_index_unit test passed");
    else
      $display("coupled_hash_bucket_index_unit test failed");
    $finish;
  end
endmodule
